// ===== rtl/sra_pkg.sv =====
// Package for the signed radix-to-ASCII converter.
// Holds the widths, the character codes, the queue entry type and the digit-to-character function.
// It depends on nothing else.
package sra_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAX_RADIX = 36;
  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int STEP_W    = $clog2(VALUE_W);
  localparam int IDX_W     = $clog2(VALUE_W);
  localparam int ND_W      = $clog2(VALUE_W + 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [RADIX_W-1:0] FALLBACK_RADIX = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] MIN_RADIX      = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX_V    = RADIX_W'(MAX_RADIX);

  localparam logic [CHAR_W-1:0] MINUS_CODE   = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] ZERO_CODE    = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] NINE_CODE    = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] UPPER_A_CODE = CHAR_W'(65);
  localparam logic [CHAR_W-1:0] UPPER_Z_CODE = CHAR_W'(90);
  localparam logic [CHAR_W-1:0] LOWER_A_CODE = CHAR_W'(97);
  localparam logic [CHAR_W-1:0] LOWER_Z_CODE = CHAR_W'(122);
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

  // One classified number waiting for conversion.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] radix;
    logic               upper;
  } sra_item_t;

  // Maps a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? UPPER_A_CODE : LOWER_A_CODE;
    if (d < DEC_DIGITS) begin
      digit_char = ZERO_CODE + CHAR_W'(d);
    end else begin
      digit_char = letter_base + CHAR_W'(d - DEC_DIGITS);
    end
  endfunction

endpackage

// ===== rtl/signed_radix_to_ascii.sv =====
// Top level of the signed radix-to-ASCII converter.
// Connects sra_front, sra_queue and sra_back; uses sra_pkg.
//
//   Channel | Direction | Handshake             | Payload
//   in      | input     | in_valid / in_ready   | in_value, in_radix, in_upper_letters
//   out     | output    | out_valid / out_ready | out_char_code, out_last
//
// The bit-serial divider produces one quotient bit per cycle and finds every digit of a
// number before any is emitted; characters then leave one per cycle unless the output
// stalls, with a minus sign first for a negative number.
// The two-entry queue lets up to two further numbers transfer in while one is converted.
// Reset is synchronous and active low; it empties the queue and the output register.
// A stalled output holds its character and pauses emission; input transfers stop only
// once the queue is full.
module signed_radix_to_ascii (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sra_pkg::VALUE_W-1:0] in_value,
  input  logic [sra_pkg::RADIX_W-1:0] in_radix,
  input  logic                        in_upper_letters,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sra_pkg::CHAR_W-1:0]  out_char_code,
  output logic                        out_last
);
  import sra_pkg::*;

  sra_item_t push_item;
  sra_item_t pop_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;

  // Classification of incoming numbers.
  sra_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_radix         (in_radix),
    .in_upper_letters (in_upper_letters),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  // Buffer between front end and engine.
  sra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  // Division and character emission.
  sra_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/sra_front.sv =====
// Front end of the converter: takes input transfers and classifies each number.
// Produces sign, magnitude and effective radix as an sra_item_t; uses sra_pkg.
module sra_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sra_pkg::VALUE_W-1:0] in_value,
  input  logic [sra_pkg::RADIX_W-1:0] in_radix,
  input  logic                        in_upper_letters,
  input  logic                        q_full,
  output logic                        q_push,
  output sra_pkg::sra_item_t          q_item
);
  import sra_pkg::*;

  logic radix_bad;

  // A transfer happens whenever the queue has room.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Out-of-range radix values fall back to decimal.
  assign radix_bad = (in_radix < MIN_RADIX) || (in_radix > MAX_RADIX_V);

  // The two's complement of the most negative value still fits as an unsigned magnitude.
  always_comb begin
    q_item.neg   = in_value[VALUE_W-1];
    q_item.mag   = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;
    q_item.radix = radix_bad ? FALLBACK_RADIX : in_radix;
    q_item.upper = in_upper_letters;
  end

endmodule

// ===== rtl/sra_queue.sv =====
// Two-entry queue that decouples the front end from the conversion engine.
// Stores sra_item_t entries from sra_pkg.
module sra_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sra_pkg::sra_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output sra_pkg::sra_item_t pop_item
);
  import sra_pkg::*;

  sra_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/sra_back.sv =====
// Conversion engine: a bit-serial restoring divider produces digits least significant first
// into a digit stack, which then drains most significant first through the output register.
// Uses sra_pkg for widths, codes and the digit-to-character function.
module sra_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  sra_pkg::sra_item_t         q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sra_pkg::CHAR_W-1:0] out_char_code,
  output logic                       out_last
);
  import sra_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_SIGN = 4'b0100,
    B_EMIT = 4'b1000
  } back_state_t;

  back_state_t        state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic [RADIX_W-1:0] rad_r, rad_nxt;
  logic [RADIX_W-1:0] rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  logic               upper_r, upper_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [CHAR_W-1:0]  stack_r [VALUE_W];

  logic [RADIX_W:0]   trial;
  logic               ge;
  logic [RADIX_W-1:0] rem_step;
  logic [VALUE_W-1:0] quo_step;
  logic               digit_done;
  logic               push_digit;
  logic [ND_W-1:0]    top_idx;
  logic               slot_free;
  logic               emit_fire;

  // One quotient bit per cycle: shift in the next dividend bit and try to subtract the radix.
  assign trial      = {rem_r, mag_r[VALUE_W-1]};
  assign ge         = (trial >= {1'b0, rad_r});
  assign rem_step   = ge ? RADIX_W'(trial - {1'b0, rad_r}) : trial[RADIX_W-1:0];
  assign quo_step   = {mag_r[VALUE_W-2:0], ge};
  assign digit_done = (step_r == STEP_W'(VALUE_W - 1));
  assign push_digit = (state_r == B_DIV) && digit_done;

  assign top_idx   = nd_r - ND_W'(1);
  assign slot_free = !out_valid_r || out_ready;
  assign emit_fire = (state_r == B_EMIT) && slot_free;

  // Sequencer for division, sign and digit emission.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    upper_nxt     = upper_r;
    step_nxt      = step_r;
    nd_nxt        = nd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          mag_nxt   = q_item.mag;
          rad_nxt   = q_item.radix;
          neg_nxt   = q_item.neg;
          upper_nxt = q_item.upper;
          rem_nxt   = '0;
          step_nxt  = '0;
          nd_nxt    = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        mag_nxt  = quo_step;
        rem_nxt  = rem_step;
        step_nxt = step_r + STEP_W'(1);
        if (digit_done) begin
          // Digit complete; the quotient becomes the next dividend.
          nd_nxt   = nd_r + ND_W'(1);
          rem_nxt  = '0;
          step_nxt = '0;
          if (quo_step == '0) begin
            state_nxt = neg_r ? B_SIGN : B_EMIT;
          end
        end
      end
      B_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = MINUS_CODE;
          out_last_nxt  = 1'b0;
          state_nxt     = B_EMIT;
        end
      end
      B_EMIT: begin
        // The character itself is read from the stack in the clocked block below.
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (nd_r == ND_W'(1));
          nd_nxt        = top_idx;
          if (nd_r == ND_W'(1)) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      nd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      nd_r        <= nd_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    upper_r    <= upper_nxt;
    out_last_r <= out_last_nxt;
  end

  // Output character: the top of the digit stack while emitting, else the sequencer's choice.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_char_r <= stack_r[top_idx[IDX_W-1:0]];
    end else begin
      out_char_r <= out_char_nxt;
    end
  end

  // Digit stack, written as each remainder completes.
  always_ff @(posedge clk) begin
    if (push_digit) begin
      stack_r[nd_r[IDX_W-1:0]] <= digit_char(rem_step, upper_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/sra_checker.sv =====
// Port-level checker for signed_radix_to_ascii, attached by the bind at the end of this file.
// Uses the character codes from sra_pkg.
module sra_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sra_pkg::CHAR_W-1:0] out_char_code,
  input logic                       out_last
);
  import sra_pkg::*;

  // A stalled output transfer keeps its character and flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("output changed while stalled");

  // Every character is a minus sign, a decimal digit or a letter.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == MINUS_CODE) ||
                  (out_char_code >= ZERO_CODE && out_char_code <= NINE_CODE) ||
                  (out_char_code >= UPPER_A_CODE && out_char_code <= UPPER_Z_CODE) ||
                  (out_char_code >= LOWER_A_CODE && out_char_code <= LOWER_Z_CODE))
    else $error("illegal character code");

  // A minus sign is always followed by digits, so it never ends a number.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == MINUS_CODE) |-> !out_last)
    else $error("minus sign marked last");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind signed_radix_to_ascii sra_checker u_sra_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for signed_radix_to_ascii. It sends signed numbers with radix and
// letter-case settings and checks every ASCII character against its own prediction.
// Depends on sra_pkg and the signed_radix_to_ascii RTL only.
module testbench;

  import sra_pkg::*;

  localparam int RANDOM_NUMBERS = 307;
  localparam int TAIL_NUMBERS   = 40;
  localparam int LONG_HOLD      = 3000;
  localparam int HOLD_AFTER     = 60;
  localparam int DRAIN_CYCLES   = 200;

  // One number to convert, as it goes onto the input ports.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               upper;
  } number_t;

  // One character as it should appear on the output ports.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } glyph_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic [RADIX_W-1:0] in_radix;
  logic               in_upper_letters;
  logic               out_valid;
  logic               out_ready;
  logic [CHAR_W-1:0]  out_char_code;
  logic               out_last;

  number_t numbers_to_send[$];
  glyph_t  expected_text[$];
  int      numbers_total;
  int      numbers_taken;
  int      chars_checked;
  int      fallback_taken;
  int      negative_taken;
  int      errors;
  logic    in_xfer;
  logic    tail_phase;
  int      send_gap;
  int      recv_gap;
  int      hold_left;
  bit      hold_done;

  signed_radix_to_ascii i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_radix         (in_radix),
    .in_upper_letters (in_upper_letters),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_code    (out_char_code),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = ~clk;
  end

  // Spells one number in its radix and appends the characters to the expected text.
  function automatic void spell_number(input number_t num);
    string             glyphs;
    logic [VALUE_W-1:0] mag;
    int unsigned       base;
    logic [CHAR_W-1:0] digits[$];
    glyph_t            g;
    glyphs = num.upper ? "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ"
                       : "0123456789abcdefghijklmnopqrstuvwxyz";
    base = (num.radix < 2 || num.radix > MAX_RADIX) ? int'(FALLBACK_RADIX) : int'(num.radix);
    // Two's complement negation in an unsigned vector gives 2^31 for the most negative value.
    mag = num.value[VALUE_W-1] ? -num.value : num.value;
    do begin
      digits.push_front(CHAR_W'(glyphs[int'(mag % base)]));
      mag = mag / base;
    end while (mag != 0);
    if (num.value[VALUE_W-1]) begin
      g.code = MINUS_CODE;
      g.last = 1'b0;
      expected_text.push_back(g);
    end
    foreach (digits[i]) begin
      g.code = digits[i];
      g.last = (i == digits.size() - 1);
      expected_text.push_back(g);
    end
  endfunction

  task automatic queue_number(input logic [VALUE_W-1:0] value, input int radix,
                              input bit upper);
    number_t num;
    num.value = value;
    num.radix = RADIX_W'(radix);
    num.upper = upper;
    numbers_to_send.push_back(num);
  endtask

  // Transfers are sampled at the rising edge: predict on input, check on output.
  always @(posedge clk) begin : check_transfers
    glyph_t want;
    number_t got_num;
    in_xfer    <= rst_n && in_valid && in_ready;
    tail_phase <= numbers_to_send.size() < TAIL_NUMBERS;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        got_num.value = in_value;
        got_num.radix = in_radix;
        got_num.upper = in_upper_letters;
        spell_number(got_num);
        numbers_taken++;
        if (in_radix < 2 || in_radix > MAX_RADIX) fallback_taken++;
        if (in_value[VALUE_W-1]) negative_taken++;
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          $error("unexpected character %0d with last=%0b", out_char_code, out_last);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code, out_char_code);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  // Sender: holds an offered number until its transfer, otherwise idles in random bursts.
  always @(negedge clk) begin : drive_numbers
    number_t next_num;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_xfer)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (numbers_to_send.size() > 0) begin
        next_num = numbers_to_send.pop_front();
        in_value         <= next_num.value;
        in_radix         <= next_num.radix;
        in_upper_letters <= next_num.upper;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off that backs up the input side.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && chars_checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    number_t num;
    in_valid         = 1'b0;
    in_value         = '0;
    in_radix         = '0;
    in_upper_letters = 1'b0;
    out_ready        = 1'b0;
    in_xfer          = 1'b0;
    tail_phase       = 1'b0;
    send_gap         = 0;
    recv_gap         = 0;
    hold_left        = 0;
    hold_done        = 1'b0;
    numbers_taken    = 0;
    chars_checked    = 0;
    fallback_taken   = 0;
    negative_taken   = 0;
    errors           = 0;
    rst_n            = 1'b0;

    // Directed numbers: zero, sign extremes, letter case, fallback radices.
    queue_number(32'd0, 10, 1'b0);
    queue_number(32'd1, 10, 1'b0);
    queue_number(32'hFFFF_FFFF, 10, 1'b0);
    queue_number(32'h7FFF_FFFF, 10, 1'b1);
    queue_number(32'h8000_0000, 10, 1'b0);
    queue_number(32'h8000_0000, 2, 1'b0);
    queue_number(32'h7FFF_FFFF, 2, 1'b1);
    queue_number(32'h8000_0000, 36, 1'b1);
    queue_number(32'h7FFF_FFFF, 36, 1'b0);
    queue_number(-32'sd35, 36, 1'b1);
    queue_number(32'd35, 36, 1'b0);
    queue_number(32'd0, 2, 1'b1);
    queue_number(32'hFFFF_FFFF, 2, 1'b0);
    queue_number(32'd123456, 0, 1'b0);
    queue_number(32'd123456, 1, 1'b1);
    queue_number(-32'sd987, 37, 1'b0);
    queue_number(32'd42, 63, 1'b1);
    queue_number(32'hFFFF_FFFF, 16, 1'b1);
    queue_number(32'hDEAD_BEEF, 16, 1'b0);
    queue_number(32'hDEAD_BEEF, 16, 1'b1);
    queue_number(32'd255, 3, 1'b0);
    queue_number(-32'sd255, 35, 1'b1);
    queue_number(-32'sh0ABC_DEF, 16, 1'b0);

    // Random numbers: mostly valid radices, some over the whole field.
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      num.upper = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9)) inside
        [0:1]:   num.radix = RADIX_W'($urandom_range(0, 63));
        2:       num.radix = RADIX_W'(10);
        default: num.radix = RADIX_W'($urandom_range(2, 36));
      endcase
      case ($urandom_range(0, 7))
        0: num.value = $urandom;
        1: num.value = VALUE_W'($urandom_range(0, 200)) - 32'd100;
        2: begin
          case ($urandom_range(0, 3))
            0:       num.value = 32'h8000_0000;
            1:       num.value = 32'h7FFF_FFFF;
            2:       num.value = 32'hFFFF_FFFF;
            default: num.value = 32'd0;
          endcase
        end
        default: begin
          num.value = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) num.value = -num.value;
        end
      endcase
      numbers_to_send.push_back(num);
    end
    numbers_total = numbers_to_send.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (numbers_taken < numbers_total) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers (%0d negative, %0d with a fallback radix) into %0d chars.",
             numbers_taken, negative_taken, fallback_taken, chars_checked);
    $display("The receiver stalled once for %0d cycles while numbers kept being offered.",
             LONG_HOLD);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #25_000_000;
    $display("Timeout with %0d characters still expected.", expected_text.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
